// ===== src/sc1kd_pkg.sv =====
package sc1kd_pkg;

    localparam logic [7:0] PREFIX_E0 = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [15:0] MOD_RESET = 16'h0080;
    localparam logic [31:0] UNKNOWN_ENTRY = 32'hF500_0000;

    typedef struct packed {
        logic       released;
        logic       is_char;
        logic       combo;
        logic [10:0] modifier_bits;
        logic [7:0] key_position;
        logic [7:0] code;
    } event_t;

    function automatic logic [31:0] rom_read(input logic [7:0] idx, input logic fr);
        logic [31:0] e;
        e = UNKNOWN_ENTRY;
        case (idx)
            8'd0:  e = 32'hff000000;
            8'd1:  e = 32'h00000000;
            8'd2:  e = fr ? 32'h21263100 : 32'h21312100;
            8'd3:  e = fr ? 32'h22e93200 : 32'h22324000;
            8'd4:  e = fr ? 32'h23223323 : 32'h23332300;
            8'd5:  e = fr ? 32'h2427347b : 32'h24342400;
            8'd6:  e = fr ? 32'h2528355b : 32'h25352500;
            8'd7:  e = fr ? 32'h262d367c : 32'h26365e00;
            8'd8:  e = fr ? 32'h27e83760 : 32'h27372600;
            8'd9:  e = fr ? 32'h285f385c : 32'h28382a00;
            8'd10: e = fr ? 32'h29e7395e : 32'h29392800;
            8'd11: e = fr ? 32'h2ae03040 : 32'h2a302900;
            8'd12: e = fr ? 32'h2b29b05d : 32'h2b2d5f00;
            8'd13: e = fr ? 32'h2c3d2b7d : 32'h2c3d2b00;
            8'd14: e = 32'h2d000000;
            8'd15: e = 32'h40000000;
            8'd16: e = fr ? 32'h41614100 : 32'h41715100;
            8'd17: e = fr ? 32'h427a5a00 : 32'h42775700;
            8'd18: e = 32'h43654500;
            8'd19: e = 32'h44725200;
            8'd20: e = 32'h45745400;
            8'd21: e = 32'h46795900;
            8'd22: e = 32'h47755500;
            8'd23: e = 32'h48694900;
            8'd24: e = 32'h496f4f00;
            8'd25: e = 32'h4a705000;
            8'd26: e = fr ? 32'h4b5ea800 : 32'h4b5b7b00;
            8'd27: e = fr ? 32'h4c24a3a4 : 32'h4c5d7d00;
            8'd28: e = 32'h4d000000;
            8'd29: e = 32'ha0000000;
            8'd30: e = fr ? 32'h61715100 : 32'h61614100;
            8'd31: e = 32'h62735300;
            8'd32: e = 32'h63644400;
            8'd33: e = 32'h64664600;
            8'd34: e = 32'h65674700;
            8'd35: e = 32'h66684800;
            8'd36: e = 32'h676a4a00;
            8'd37: e = 32'h686b4b00;
            8'd38: e = 32'h696c4c00;
            8'd39: e = fr ? 32'h6a6d4d00 : 32'h6a3b3a00;
            8'd40: e = fr ? 32'h6bf92500 : 32'h6b272200;
            8'd41: e = fr ? 32'h20b20000 : 32'h20607e00;
            8'd42: e = 32'h80000000;
            8'd43: e = fr ? 32'h6c2ab500 : 32'h6c5c7c00;
            8'd44: e = fr ? 32'h82775700 : 32'h827a5a00;
            8'd45: e = 32'h83785800;
            8'd46: e = 32'h84634300;
            8'd47: e = 32'h85765600;
            8'd48: e = 32'h86624200;
            8'd49: e = 32'h876e4e00;
            8'd50: e = fr ? 32'h882c3f00 : 32'h886d4d00;
            8'd51: e = fr ? 32'h893b2e00 : 32'h892c3c00;
            8'd52: e = fr ? 32'h8a3a2f00 : 32'h8a2e3e00;
            8'd53: e = fr ? 32'h8b21a700 : 32'h8b2f3f00;
            8'd54: e = 32'h8c000000;
            8'd55: e = 32'h332a0000;
            8'd56: e = 32'ha3000000;
            8'd57: e = 32'ha4000000;
            8'd58: e = 32'h60000000;
            8'd59: e = 32'h01000000;
            8'd60: e = 32'h02000000;
            8'd61: e = 32'h03000000;
            8'd62: e = 32'h04000000;
            8'd63: e = 32'h05000000;
            8'd64: e = 32'h06000000;
            8'd65: e = 32'h07000000;
            8'd66: e = 32'h08000000;
            8'd67: e = 32'h09000000;
            8'd68: e = 32'h0a000000;
            8'd69: e = 32'h31000000;
            8'd71: e = 32'h51370000;
            8'd72: e = 32'h52380000;
            8'd73: e = 32'h53390000;
            8'd74: e = 32'h342d0000;
            8'd75: e = 32'h71340000;
            8'd76: e = 32'h72350000;
            8'd77: e = 32'h73360000;
            8'd78: e = 32'h542b0000;
            8'd79: e = 32'h91310000;
            8'd80: e = 32'h92320000;
            8'd81: e = 32'h93330000;
            8'd82: e = 32'hb1300000;
            8'd83: e = 32'hb32e0000;
            8'd86: e = 32'h813c3e00;
            8'd87: e = 32'h0b000000;
            8'd88: e = 32'h0c000000;
            8'h9c: e = 32'h94000000;
            8'h9d: e = 32'ha6000000;
            8'hb5: e = 32'h322f0000;
            8'hb8: e = 32'ha5000000;
            8'hc7: e = 32'h2f000000;
            8'hc8: e = 32'h8f000000;
            8'hc9: e = 32'h30000000;
            8'hcb: e = 32'hae000000;
            8'hcd: e = 32'hb0000000;
            8'hd0: e = 32'haf000000;
            8'hd1: e = 32'h50000000;
            8'hd2: e = 32'h2e000000;
            8'hd3: e = 32'h4e000000;
            default: e = UNKNOWN_ENTRY;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] special_code(input logic [7:0] p);
        logic [7:0] s;
        case (p)
            8'hff: s = 8'd0;
            8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
            8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c: s = p;
            8'h31: s = 8'd13;
            8'h60: s = 8'd14;
            8'ha0: s = 8'd15;
            8'ha6: s = 8'd16;
            8'h80: s = 8'd17;
            8'h8c: s = 8'd18;
            8'ha3: s = 8'd19;
            8'ha5: s = 8'd20;
            8'h00: s = 8'd25;
            8'h2d: s = 8'd26;
            8'h4e, 8'hb3: s = 8'd27;
            8'h2e, 8'hb1: s = 8'd28;
            8'h40: s = 8'd29;
            8'h4d, 8'h94: s = 8'd30;
            8'ha4: s = 8'd32;
            8'h8f, 8'h52: s = 8'd40;
            8'hae, 8'h71: s = 8'd41;
            8'hb0, 8'h73: s = 8'd42;
            8'haf, 8'h92: s = 8'd43;
            8'h30, 8'h53: s = 8'd44;
            8'h50, 8'h93: s = 8'd45;
            8'h2f, 8'h51: s = 8'd46;
            8'h91: s = 8'd47;
            default: s = 8'd255;
        endcase
        return s;
    endfunction

endpackage

// ===== src/scancode_set1_key_decoder.sv =====
// The key event of an accepted scancode byte is registered and shown on m_; E0 and 0x00 give no event.
// Throughput: one byte per cycle while s_tready is high; the modifier update and layout lookup are combinational.
// The output register holds a result under back-pressure; s_tready stays high while it
// is empty or being taken.
// Reset (aresetn low, synchronous): modifiers 0x0080 (num lock on), AZERTY, no result pending.
module scancode_set1_key_decoder
    import sc1kd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] released, [1] is_char, [2] combo, [13:3] modifier_bits,
    // [21:14] key_position, [29:22] code, [31:30] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data    // layout_select: 1 AZERTY, 0 QWERTY
);
    logic [15:0] mod_reg, mod_next, mod_upd;
    logic        layout_reg;
    logic        valid_reg, valid_next;
    event_t      ev_reg, ev;
    logic        take, press, gives_event;
    logic [7:0]  idx;

    // The result register can be refilled in the same cycle it is drained.
    assign s_tready  = !valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign take      = s_tvalid && s_tready;

    // The key index replaces the release bit with the extension flag.
    assign press       = !s_tdata[7];
    assign idx         = {mod_reg[15], s_tdata[6:0]};
    assign gives_event = (s_tdata != PREFIX_E0) && (s_tdata != 8'd0);

    // Modifier update; caps lock and num lock toggle on press only.
    always_comb begin
        mod_upd = mod_reg;
        if (idx == {1'b0, KEY_LSHIFT}) mod_upd[0] = press;
        if (idx == {1'b0, KEY_RSHIFT}) mod_upd[1] = press;
        if (idx == {1'b0, KEY_CAPS} && press) mod_upd[2] = !mod_reg[2];
        if (idx == {1'b0, KEY_CTRL}) mod_upd[3] = press;
        if (idx == {1'b1, KEY_CTRL}) mod_upd[4] = press;
        if (idx == {1'b0, KEY_ALT}) mod_upd[5] = press;
        if (idx == {1'b1, KEY_ALT}) mod_upd[6] = press;
        if (idx == {1'b0, KEY_NUM} && press) mod_upd[7] = !mod_reg[7];
        mod_upd[8]  = mod_upd[2] != (mod_upd[1] || mod_upd[0]);
        mod_upd[9]  = mod_upd[3] || mod_upd[4];
        mod_upd[10] = mod_upd[6] || (mod_upd[9] && mod_upd[5]);

        mod_next = mod_reg;
        if (take) begin
            if (s_tdata == PREFIX_E0) begin
                mod_next[15] = 1'b1;
            end else if (gives_event) begin
                mod_next = {2'b00, mod_upd[13:0]};
            end
        end
        valid_next = valid_reg;
        if (m_tready) valid_next = 1'b0;
        if (take && gives_event) valid_next = 1'b1;
    end

    sc1kd_lookup u_lookup (
        .idx      (idx),
        .released (!press),
        .layout_fr(layout_reg),
        .mods     (mod_upd[10:0]),
        .ev       (ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg    <= MOD_RESET;
            layout_reg <= 1'b1;
            valid_reg  <= 1'b0;
        end else begin
            mod_reg   <= mod_next;
            valid_reg <= valid_next;
            if (cfg_valid) layout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && gives_event) ev_reg <= ev;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, ev_reg.code, ev_reg.key_position, ev_reg.modifier_bits,
                       ev_reg.combo, ev_reg.is_char, ev_reg.released};
endmodule

// ===== src/sc1kd_lookup.sv =====
module sc1kd_lookup
    import sc1kd_pkg::*;
(
    input  logic [7:0]  idx,
    input  logic        released,
    input  logic        layout_fr,
    input  logic [10:0] mods,
    output event_t      ev
);
    logic [31:0] ent;
    logic [7:0]  posn, norm, ch;
    logic        combo, keypad, ischar;

    // Character selection: shift column, AltGr column, else normal; a combo or an empty entry uses normal.
    always_comb begin
        ent   = rom_read(idx, layout_fr);
        posn  = ent[31:24];
        norm  = ent[23:16];
        combo = (mods[9] != mods[5]) || (mods[8] && mods[10]);
        if (!combo && mods[8]) begin
            ch = ent[15:8];
        end else if (!combo && mods[10]) begin
            ch = ent[7:0];
        end else begin
            ch = norm;
        end
        if (ch == 8'd0) begin
            ch = norm;
        end
        keypad = (posn[4:0] >= 5'd17) && !mods[7];
        ischar = (ch != 8'd0) && !keypad;
        ev.released      = released;
        ev.is_char       = ischar;
        ev.combo         = combo;
        ev.modifier_bits = mods;
        ev.key_position  = posn;
        ev.code          = ischar ? ch : special_code(posn);
    end
endmodule

// ===== src/sc1kd_checker.sv =====
module sc1kd_checker
    import sc1kd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // A prefix or zero byte never produces a result when the output was empty.
    a_noevt: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid && s_tready && (s_tdata == PREFIX_E0 || s_tdata == 8'h00)
        |=> !m_tvalid)
        else $error("prefix or zero byte produced an event");

    // Any other accepted byte produces a result next cycle.
    a_evt: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata != PREFIX_E0 && s_tdata != 8'h00 |=> m_tvalid)
        else $error("missing event");

    // Release flag follows bit 7 of the byte.
    a_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata != PREFIX_E0 && s_tdata != 8'h00
        |=> m_tdata[0] == $past(s_tdata[7]))
        else $error("release flag mismatch");
endmodule

bind scancode_set1_key_decoder sc1kd_checker u_sc1kd_checker (.*);

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sc1kd_pkg::*;

    localparam int  CLK_HALF    = 2;
    localparam int  RESET_CYC   = 12;
    localparam int  RAND_ITEMS  = 120;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  TAIL_CYC    = 3;

    // Layout entries: position, normal, shift and AltGr bytes from the top down.
    localparam logic [31:0] AZERTY_LO [54] = '{
        32'hff000000, 32'h00000000, 32'h21263100, 32'h22e93200, 32'h23223323, 32'h2427347b,
        32'h2528355b, 32'h262d367c, 32'h27e83760, 32'h285f385c, 32'h29e7395e, 32'h2ae03040,
        32'h2b29b05d, 32'h2c3d2b7d, 32'h2d000000, 32'h40000000, 32'h41614100, 32'h427a5a00,
        32'h43654500, 32'h44725200, 32'h45745400, 32'h46795900, 32'h47755500, 32'h48694900,
        32'h496f4f00, 32'h4a705000, 32'h4b5ea800, 32'h4c24a3a4, 32'h4d000000, 32'ha0000000,
        32'h61715100, 32'h62735300, 32'h63644400, 32'h64664600, 32'h65674700, 32'h66684800,
        32'h676a4a00, 32'h686b4b00, 32'h696c4c00, 32'h6a6d4d00, 32'h6bf92500, 32'h20b20000,
        32'h80000000, 32'h6c2ab500, 32'h82775700, 32'h83785800, 32'h84634300, 32'h85765600,
        32'h86624200, 32'h876e4e00, 32'h882c3f00, 32'h893b2e00, 32'h8a3a2f00, 32'h8b21a700};
    localparam logic [31:0] QWERTY_LO [54] = '{
        32'hff000000, 32'h00000000, 32'h21312100, 32'h22324000, 32'h23332300, 32'h24342400,
        32'h25352500, 32'h26365e00, 32'h27372600, 32'h28382a00, 32'h29392800, 32'h2a302900,
        32'h2b2d5f00, 32'h2c3d2b00, 32'h2d000000, 32'h40000000, 32'h41715100, 32'h42775700,
        32'h43654500, 32'h44725200, 32'h45745400, 32'h46795900, 32'h47755500, 32'h48694900,
        32'h496f4f00, 32'h4a705000, 32'h4b5b7b00, 32'h4c5d7d00, 32'h4d000000, 32'ha0000000,
        32'h61614100, 32'h62735300, 32'h63644400, 32'h64664600, 32'h65674700, 32'h66684800,
        32'h676a4a00, 32'h686b4b00, 32'h696c4c00, 32'h6a3b3a00, 32'h6b272200, 32'h20607e00,
        32'h80000000, 32'h6c5c7c00, 32'h827a5a00, 32'h83785800, 32'h84634300, 32'h85765600,
        32'h86624200, 32'h876e4e00, 32'h886d4d00, 32'h892c3c00, 32'h8a2e3e00, 32'h8b2f3f00};
    // Entries 54 through 89 do not depend on the layout.
    localparam logic [31:0] SHARED_MID [36] = '{
        32'h8c000000, 32'h332a0000, 32'ha3000000, 32'ha4000000, 32'h60000000, 32'h01000000,
        32'h02000000, 32'h03000000, 32'h04000000, 32'h05000000, 32'h06000000, 32'h07000000,
        32'h08000000, 32'h09000000, 32'h0a000000, 32'h31000000, 32'hf5000000, 32'h51370000,
        32'h52380000, 32'h53390000, 32'h342d0000, 32'h71340000, 32'h72350000, 32'h73360000,
        32'h542b0000, 32'h91310000, 32'h92320000, 32'h93330000, 32'hb1300000, 32'hb32e0000,
        32'hf5000000, 32'hf5000000, 32'h813c3e00, 32'h0b000000, 32'h0c000000, 32'hf5000000};

    // Modifier register bit positions.
    localparam int MB_LSHIFT = 0;
    localparam int MB_RSHIFT = 1;
    localparam int MB_CAPS   = 2;
    localparam int MB_LCTRL  = 3;
    localparam int MB_RCTRL  = 4;
    localparam int MB_LALT   = 5;
    localparam int MB_RALT   = 6;
    localparam int MB_NUM    = 7;
    localparam int MB_GSHIFT = 8;
    localparam int MB_GCTRL  = 9;
    localparam int MB_ALTGR  = 10;
    localparam int MB_EXT    = 15;

    localparam logic       LAYOUT_AZERTY = 1'b1;
    localparam logic       LAYOUT_QWERTY = 1'b0;
    localparam logic [7:0] BYTE_NONE     = 8'h00;
    localparam logic [7:0] RELEASE_BIT   = 8'h80;

    // Keeps its own copy of the modifier register and the layout and holds
    // the key events still owed by the decoder, oldest first.
    class key_event_board;
        logic [15:0] mods;
        logic        azerty;
        event_t      pending_events[$];
        int          errors;

        function new();
            mods   = MOD_RESET;
            azerty = LAYOUT_AZERTY;
            errors = 0;
        endfunction

        function logic [31:0] layout_entry(logic [7:0] idx);
            if (idx < 54)
                return azerty ? AZERTY_LO[idx] : QWERTY_LO[idx];
            if (idx < 90)
                return SHARED_MID[idx - 54];
            case (idx)
                8'h9c: return 32'h94000000;
                8'h9d: return 32'ha6000000;
                8'hb5: return 32'h322f0000;
                8'hb8: return 32'ha5000000;
                8'hc7: return 32'h2f000000;
                8'hc8: return 32'h8f000000;
                8'hc9: return 32'h30000000;
                8'hcb: return 32'hae000000;
                8'hcd: return 32'hb0000000;
                8'hd0: return 32'haf000000;
                8'hd1: return 32'h50000000;
                8'hd2: return 32'h2e000000;
                8'hd3: return 32'h4e000000;
                default: return UNKNOWN_ENTRY;
            endcase
        endfunction

        function logic [7:0] key_code_of(logic [7:0] p);
            case (p)
                8'hff: return 8'd0;
                8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c: return p;
                8'h31: return 8'd13;
                8'h60: return 8'd14;
                8'ha0: return 8'd15;
                8'ha6: return 8'd16;
                8'h80: return 8'd17;
                8'h8c: return 8'd18;
                8'ha3: return 8'd19;
                8'ha5: return 8'd20;
                8'h00: return 8'd25;
                8'h2d: return 8'd26;
                8'h4e, 8'hb3: return 8'd27;
                8'h2e, 8'hb1: return 8'd28;
                8'h40: return 8'd29;
                8'h4d, 8'h94: return 8'd30;
                8'ha4: return 8'd32;
                8'h8f, 8'h52: return 8'd40;
                8'hae, 8'h71: return 8'd41;
                8'hb0, 8'h73: return 8'd42;
                8'haf, 8'h92: return 8'd43;
                8'h30, 8'h53: return 8'd44;
                8'h50, 8'h93: return 8'd45;
                8'h2f, 8'h51: return 8'd46;
                8'h91: return 8'd47;
                default: return 8'd255;
            endcase
        endfunction

        // Lock keys flip on press only; the others follow the key.
        function void update_key(int n, logic down);
            if (n == MB_CAPS || n == MB_NUM)
                mods[n] = mods[n] ^ down;
            else
                mods[n] = down;
        endfunction

        function void note_scan_byte(logic [7:0] b);
            logic        down;
            logic        combo;
            logic        keypad;
            logic        ischar;
            logic [7:0]  idx;
            logic [31:0] ent;
            logic [7:0]  ch;
            event_t      ev;
            if (b == PREFIX_E0) begin
                mods[MB_EXT] = 1'b1;
                return;
            end
            if (b == BYTE_NONE)
                return;
            down = ~b[7];
            idx  = {mods[MB_EXT], b[6:0]};
            case (idx)
                {1'b0, KEY_LSHIFT}: update_key(MB_LSHIFT, down);
                {1'b0, KEY_RSHIFT}: update_key(MB_RSHIFT, down);
                {1'b0, KEY_CAPS}:   update_key(MB_CAPS, down);
                {1'b0, KEY_CTRL}:   update_key(MB_LCTRL, down);
                {1'b1, KEY_CTRL}:   update_key(MB_RCTRL, down);
                {1'b0, KEY_ALT}:    update_key(MB_LALT, down);
                {1'b1, KEY_ALT}:    update_key(MB_RALT, down);
                {1'b0, KEY_NUM}:    update_key(MB_NUM, down);
                default: ;
            endcase
            mods[MB_GSHIFT] = mods[MB_CAPS] ^ (mods[MB_LSHIFT] | mods[MB_RSHIFT]);
            mods[MB_GCTRL]  = mods[MB_LCTRL] | mods[MB_RCTRL];
            mods[MB_ALTGR]  = mods[MB_RALT] | (mods[MB_GCTRL] & mods[MB_LALT]);

            ent   = layout_entry(idx);
            combo = (mods[MB_GCTRL] ^ mods[MB_LALT]) | (mods[MB_GSHIFT] & mods[MB_ALTGR]);
            // With a combo active only the normal column is used.
            if (!combo && mods[MB_GSHIFT])
                ch = ent[15:8];
            else if (!combo && mods[MB_ALTGR])
                ch = ent[7:0];
            else
                ch = ent[23:16];
            if (ch == 8'h00)
                ch = ent[23:16];
            // Keypad columns give their key code while num lock is off.
            keypad = (ent[28:24] >= 5'd17) && !mods[MB_NUM];
            ischar = (ch != 8'h00) && !keypad;

            ev.released      = ~down;
            ev.is_char       = ischar;
            ev.combo         = combo;
            ev.modifier_bits = mods[10:0];
            ev.key_position  = ent[31:24];
            ev.code          = ischar ? ch : key_code_of(ent[31:24]);
            pending_events.push_back(ev);
            mods = mods & 16'h3fff;
        endfunction

        function void compare_field(string name, logic [10:0] exp_v, logic [10:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_key_event(logic [31:0] word);
            event_t ev;
            if (pending_events.size() == 0) begin
                $error("key event 0x%08h arrived with none expected", word);
                errors++;
                return;
            end
            ev = pending_events.pop_front();
            compare_field("released", ev.released, word[0]);
            compare_field("is_char", ev.is_char, word[1]);
            compare_field("combo", ev.combo, word[2]);
            compare_field("modifier_bits", ev.modifier_bits, word[13:3]);
            compare_field("key_position", ev.key_position, word[21:14]);
            compare_field("code", ev.code, word[29:22]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] scan_byte
    logic        m_tvalid;
    logic        m_tready;
    // [0] released, [1] is_char, [2] combo, [13:3] modifier_bits,
    // [21:14] key_position, [29:22] code, [31:30] zero
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;   // layout_select

    key_event_board board;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             cycle_count;

    scancode_set1_key_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // The receiver drops tready at random according to the phase's idle rate.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both handshakes are observed at the rising edge, where every input
    // has been steady since the falling edge before it. A result seen at this
    // edge belongs to a byte taken at an earlier one, so the order of the two
    // checks does not matter.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_key_event(m_tdata);
            if (s_tvalid && s_tready)
                board.note_scan_byte(s_tdata);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one byte and holds it until the decoder takes it. Gaps are
    // inserted in front of the byte, so valid is only lowered when a gap falls.
    task automatic send_scan_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits for every owed key event, then idles a while longer so that any
    // byte still in flight has settled before the next layout write.
    task automatic drain_events();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending_events.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
    endtask

    task automatic write_layout(input logic sel);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do @(posedge aclk); while (!cfg_ready);
        board.azerty = sel;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Presses and releases around the modifier keys, both locks included,
    // plus the prefix, ignored bytes, and ordinary keys.
    task automatic run_directed();
        logic [7:0] seq[$];
        seq = '{8'h01, 8'h81, 8'h10, 8'h2A, 8'h10, 8'hAA, 8'hE0, 8'h38, 8'h04,
                8'h36, 8'h04, 8'hB6, 8'hE0, 8'hB8, 8'h1D, 8'h38, 8'h10, 8'h9D,
                8'hB8, 8'h3A, 8'hBA, 8'h1B, 8'h3A, 8'h45, 8'hC5, 8'h47, 8'h45,
                8'h00, 8'hE0, 8'hE0, 8'h00, 8'h1D, 8'hE0, 8'hFA, 8'hFF, 8'h80,
                8'h7F};
        foreach (seq[i])
            send_scan_byte(seq[i]);
    endtask

    // Mostly well-formed key strokes with random keys and modifiers, the rest
    // extended keys and raw noise over the whole byte range.
    task automatic run_random(input int count);
        logic [7:0] mod_keys[8];
        logic [7:0] key;
        int         pick;
        mod_keys = '{8'h2A, 8'h36, 8'h3A, 8'h1D, 8'h38, 8'h45, 8'h1D, 8'h38};
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                key = 8'($urandom_range(1, 88));
                send_scan_byte(key);
                if ($urandom_range(1))
                    send_scan_byte(key | RELEASE_BIT);
            end else if (pick < 65) begin
                key = mod_keys[$urandom_range(7)];
                if (key == 8'h1D || key == 8'h38 && $urandom_range(1))
                    send_scan_byte(PREFIX_E0);
                send_scan_byte(key | ($urandom_range(1) ? RELEASE_BIT : BYTE_NONE));
            end else if (pick < 85) begin
                send_scan_byte(PREFIX_E0);
                send_scan_byte(8'($urandom_range(255)));
            end else begin
                send_scan_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        board         = new();
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = LAYOUT_AZERTY;
        repeat (RESET_CYC) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // First phase runs at the reset layout with a rare sender gap and a
        // mostly stalled receiver; the second swaps those rates on QWERTY.
        send_idle_pct = 6;
        recv_idle_pct = 76;
        run_directed();
        run_random(RAND_ITEMS);
        drain_events();

        write_layout(LAYOUT_QWERTY);
        send_idle_pct = 76;
        recv_idle_pct = 6;
        run_directed();
        run_random(RAND_ITEMS);
        drain_events();

        // Back-to-back traffic on both layouts.
        write_layout(LAYOUT_AZERTY);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RAND_ITEMS);
        drain_events();

        write_layout(LAYOUT_QWERTY);
        run_random(RAND_ITEMS);
        drain_events();

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== scancode_set1_key_decoder.f =====
src/sc1kd_pkg.sv
src/sc1kd_lookup.sv
src/scancode_set1_key_decoder.sv
src/sc1kd_checker.sv
test/tb.sv
